@@ rtl/sirt_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sirt_pkg
// Shared types and constants for the signed integer to radix text converter.
// ----------------------------------------------------------------------------
package sirt_pkg;

    // Fixed port widths
    localparam int VALUE_W     = 32;
    localparam int CHAR_W      = 8;
    localparam int BASE_LEN_W  = 5;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 64;

    // Quotient bits resolved by the shared divide unit per cycle
    localparam int DIV_STEP_BITS = 8;

    // Special characters
    localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;

    // Register indexes on the configuration port
    localparam logic [CFG_INDEX_W-1:0] REG_BASE_LEN     = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_SYMBOLS_LOW  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_SYMBOLS_HIGH = 2'd2;

    // Reset configuration: radix 10, symbols "0123456789"
    localparam logic [BASE_LEN_W-1:0] RST_BASE_LEN = 5'd10;
    localparam logic [2*CFG_DATA_W-1:0] RST_SYMBOLS =
        {64'd14648, 64'd3978425819141910832};

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_START,
        ST_DIVIDE,
        ST_EMIT
    } state_t;

endpackage

@@ rtl/sirt_table_check.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sirt_table_check
// Validates the configured symbol table and registers the radix in use
// (zero when the table is unusable).
// ----------------------------------------------------------------------------
module sirt_table_check #(
    parameter int MAX_SYMBOLS = 16
) (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic [sirt_pkg::BASE_LEN_W-1:0]         base_len,
    input  logic [MAX_SYMBOLS-1:0][sirt_pkg::CHAR_W-1:0] symbols,
    output logic [$clog2(MAX_SYMBOLS+1)-1:0]        radix
);
    import sirt_pkg::*;

    localparam int RADIX_W = $clog2(MAX_SYMBOLS + 1);

    logic [BASE_LEN_W-1:0] len;
    logic                  bad;
    logic [RADIX_W-1:0]    radix_next;
    logic [RADIX_W-1:0]    radix_reg;

    // Saturate length, then look for forbidden or repeated symbols
    always_comb begin
        if (base_len > BASE_LEN_W'(MAX_SYMBOLS)) begin
            len = BASE_LEN_W'(MAX_SYMBOLS);
        end else begin
            len = base_len;
        end
        bad = (len < BASE_LEN_W'(2));
        for (int i = 0; i < MAX_SYMBOLS; i++) begin
            if (BASE_LEN_W'(i) < len) begin
                if (symbols[i] == '0 || symbols[i] == CH_PLUS ||
                    symbols[i] == CH_MINUS) begin
                    bad = 1'b1;
                end
                for (int j = i + 1; j < MAX_SYMBOLS; j++) begin
                    if (BASE_LEN_W'(j) < len && symbols[j] == symbols[i]) begin
                        bad = 1'b1;
                    end
                end
            end
        end
        radix_next = bad ? '0 : RADIX_W'(len);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radix_reg <= '0;
        end else begin
            radix_reg <= radix_next;
        end
    end

    assign radix = radix_reg;

endmodule

@@ rtl/sirt_div_step.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sirt_div_step
// Shared divide unit: resolves one chunk of quotient bits of a long division
// by a small radix, carrying the running remainder in and out.
// ----------------------------------------------------------------------------
module sirt_div_step #(
    parameter int MAX_SYMBOLS = 16
) (
    input  logic [$clog2(MAX_SYMBOLS)-1:0]      rem_in,
    input  logic [sirt_pkg::DIV_STEP_BITS-1:0]  chunk_in,
    input  logic [$clog2(MAX_SYMBOLS+1)-1:0]    radix,
    output logic [sirt_pkg::DIV_STEP_BITS-1:0]  quot,
    output logic [$clog2(MAX_SYMBOLS)-1:0]      rem_out
);
    import sirt_pkg::*;

    localparam int REM_W = $clog2(MAX_SYMBOLS);

    logic [REM_W:0]   radix_ext;
    logic [REM_W:0]   trial;
    logic [REM_W-1:0] rem;

    // Restoring division, most significant bit first
    always_comb begin
        radix_ext = (REM_W + 1)'(radix);
        rem       = rem_in;
        trial     = '0;
        quot      = '0;
        for (int i = DIV_STEP_BITS - 1; i >= 0; i--) begin
            trial = {rem, chunk_in[i]};
            if (trial >= radix_ext) begin
                trial   = trial - radix_ext;
                quot[i] = 1'b1;
            end
            rem = trial[REM_W-1:0];
        end
        rem_out = rem;
    end

endmodule

@@ rtl/signed_int_to_radix_text.sv @@
`timescale 1ns / 1ps
// After an input transaction the sequencer checks the table, then divides
// out the digits one chunk at a time with the shared divider, which
// resolves 8 quotient bits per cycle; characters then leave one per
// cycle while m_ready is high. A new value is taken only once the last
// character of the value before it has been issued.
// Reset: radix 10 with symbols "0123456789", sequencer idle, no output valid.
// ----------------------------------------------------------------------------
// signed_int_to_radix_text
// Converts a signed integer into its text in a configurable radix, one
// character per output transaction, with last on the final character.
// ----------------------------------------------------------------------------
module signed_int_to_radix_text #(
    parameter int MAX_SYMBOLS = 16,
    parameter int VALUE_BITS  = 32
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // configuration write port
    input  logic                              cfg_wr_en,
    input  logic [sirt_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [sirt_pkg::CFG_DATA_W-1:0]   cfg_wr_data,
    // input channel
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic signed [sirt_pkg::VALUE_W-1:0] s_value,
    // result channel
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [sirt_pkg::CHAR_W-1:0]       m_text_char,
    output logic                              m_last
);
    import sirt_pkg::*;

    localparam int RADIX_W = $clog2(MAX_SYMBOLS + 1);
    localparam int REM_W   = $clog2(MAX_SYMBOLS);
    localparam int DIGITS  = VALUE_BITS;
    localparam int IDX_W   = $clog2(DIGITS);
    localparam int CNT_W   = $clog2(DIGITS + 1);
    localparam int CHUNKS  = (VALUE_BITS + DIV_STEP_BITS - 1) / DIV_STEP_BITS;
    localparam int CHUNK_W = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;
    localparam int DIV_W   = CHUNKS * DIV_STEP_BITS;

    // Configuration registers
    logic [BASE_LEN_W-1:0]                base_len_reg;
    logic [MAX_SYMBOLS-1:0][CHAR_W-1:0]   sym_reg;
    logic [RADIX_W-1:0]                   radix;

    // Sequencer and datapath registers
    state_t                state_reg, state_next;
    logic [DIV_W-1:0]      dividend_reg, dividend_next;
    logic [REM_W-1:0]      rem_reg, rem_next;
    logic [CHUNK_W-1:0]    chunk_reg, chunk_next;
    logic                  qnz_reg, qnz_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic [CNT_W-1:0]      emit_idx_reg, emit_idx_next;
    logic                  neg_reg, neg_next;
    logic                  m_valid_reg, m_valid_next;
    logic [CHAR_W-1:0]     m_char_reg, m_char_next;
    logic                  m_last_reg, m_last_next;

    // Digit store, written before read
    logic [REM_W-1:0]      digit_mem [DIGITS];
    logic                  digit_we;

    // Shared divider connections
    logic [DIV_STEP_BITS-1:0] div_quot;
    logic [REM_W-1:0]         div_rem;

    logic [VALUE_BITS-1:0] in_bits;
    logic [VALUE_BITS-1:0] in_mag;
    logic [IDX_W-1:0]      rd_idx;
    logic [REM_W-1:0]      rd_digit;
    logic                  out_free;

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_len_reg <= RST_BASE_LEN;
        end else if (cfg_wr_en && cfg_index == REG_BASE_LEN) begin
            base_len_reg <= cfg_wr_data[BASE_LEN_W-1:0];
        end
    end

    // Symbol table: symbols 0 to 7 in the low word, 8 upwards in the high word
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sym_reg <= RST_SYMBOLS[MAX_SYMBOLS*CHAR_W-1:0];
        end else if (cfg_wr_en) begin
            for (int k = 0; k < MAX_SYMBOLS; k++) begin
                if (cfg_index == ((k < 8) ? REG_SYMBOLS_LOW : REG_SYMBOLS_HIGH)) begin
                    sym_reg[k] <= cfg_wr_data[(k & 7)*CHAR_W +: CHAR_W];
                end
            end
        end
    end

    sirt_table_check #(
        .MAX_SYMBOLS (MAX_SYMBOLS)
    ) u_check (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .base_len (base_len_reg),
        .symbols  (sym_reg),
        .radix    (radix)
    );

    sirt_div_step #(
        .MAX_SYMBOLS (MAX_SYMBOLS)
    ) u_div (
        .rem_in   (rem_reg),
        .chunk_in (dividend_reg[DIV_W-1 -: DIV_STEP_BITS]),
        .radix    (radix),
        .quot     (div_quot),
        .rem_out  (div_rem)
    );

    // Input magnitude; the most negative value maps onto 2^(VALUE_BITS-1)
    assign in_bits = s_value[VALUE_BITS-1:0];
    assign in_mag  = in_bits[VALUE_BITS-1] ? (~in_bits + 1'b1) : in_bits;

    assign rd_idx   = IDX_W'(emit_idx_reg - 1'b1);
    assign rd_digit = digit_mem[rd_idx];
    assign out_free = !m_valid_reg || m_ready;

    // Sequencer state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        dividend_reg <= dividend_next;
        rem_reg      <= rem_next;
        chunk_reg    <= chunk_next;
        qnz_reg      <= qnz_next;
        count_reg    <= count_next;
        emit_idx_reg <= emit_idx_next;
        neg_reg      <= neg_next;
        m_char_reg   <= m_char_next;
        m_last_reg   <= m_last_next;
    end

    // Digit store write
    always_ff @(posedge aclk) begin
        if (digit_we) begin
            digit_mem[count_reg[IDX_W-1:0]] <= div_rem;
        end
    end

    // Next state and datapath control
    always_comb begin
        state_next    = state_reg;
        dividend_next = dividend_reg;
        rem_next      = rem_reg;
        chunk_next    = chunk_reg;
        qnz_next      = qnz_reg;
        count_next    = count_reg;
        emit_idx_next = emit_idx_reg;
        neg_next      = neg_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_char_next   = m_char_reg;
        m_last_next   = m_last_reg;
        digit_we      = 1'b0;
        s_ready       = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    dividend_next = DIV_W'(in_mag);
                    neg_next      = in_bits[VALUE_BITS-1];
                    rem_next      = '0;
                    chunk_next    = '0;
                    qnz_next      = 1'b0;
                    count_next    = '0;
                    state_next    = ST_START;
                end
            end
            // registered table check; an unusable table drops the value
            ST_START: begin
                if (radix == '0) begin
                    state_next = ST_IDLE;
                end else begin
                    state_next = ST_DIVIDE;
                end
            end
            // one chunk of the long division per cycle
            ST_DIVIDE: begin
                dividend_next = (dividend_reg << DIV_STEP_BITS) | DIV_W'(div_quot);
                qnz_next      = qnz_reg || (div_quot != '0);
                if (chunk_reg == CHUNK_W'(CHUNKS - 1)) begin
                    digit_we   = 1'b1;
                    count_next = count_reg + 1'b1;
                    rem_next   = '0;
                    chunk_next = '0;
                    qnz_next   = 1'b0;
                    if (!(qnz_reg || (div_quot != '0)) ||
                        count_reg >= CNT_W'(DIGITS - 1)) begin
                        emit_idx_next = count_reg + 1'b1;
                        state_next    = ST_EMIT;
                    end
                end else begin
                    chunk_next = chunk_reg + 1'b1;
                    rem_next   = div_rem;
                end
            end
            // sign first, then digits most significant first
            ST_EMIT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    if (neg_reg) begin
                        m_char_next = CH_MINUS;
                        m_last_next = 1'b0;
                        neg_next    = 1'b0;
                    end else begin
                        m_char_next   = sym_reg[rd_digit];
                        m_last_next   = (emit_idx_reg == CNT_W'(1));
                        emit_idx_next = emit_idx_reg - 1'b1;
                        if (emit_idx_reg == CNT_W'(1)) begin
                            state_next = ST_IDLE;
                        end
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_valid     = m_valid_reg;
    assign m_text_char = m_char_reg;
    assign m_last      = m_last_reg;

endmodule
